FILE: src/sep_pkg.sv
// shared types, constants and hash functions for the sha-512 entropy pool
package sep_pkg;

  typedef logic [7:0][63:0]  sep_state_t;
  typedef logic [15:0][63:0] sep_sched_t;

  localparam logic [1:0] OP_ABS = 2'd0;
  localparam logic [1:0] OP_GEN = 2'd1;
  localparam logic [1:0] OP_RSD = 2'd2;

  localparam logic [1:0] FUNC_CREDIT = 2'd0;
  localparam logic [1:0] FUNC_SEED   = 2'd1;
  localparam logic [1:0] FUNC_GEN    = 2'd2;

  localparam logic [9:0] ENTROPY_CAP = 10'd512;

  localparam logic [63:0] SHA_IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] SHA_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // "reseed" followed by a nul byte
  function automatic logic [7:0] tag_byte(input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = 8'h72;
      3'd1:    b = 8'h65;
      3'd2:    b = 8'h73;
      3'd3:    b = 8'h65;
      3'd4:    b = 8'h65;
      3'd5:    b = 8'h64;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: src/sep_round.sv
// one sha-512 round plus one message schedule step
module sep_round
  import sep_pkg::*;
(
  input  sep_state_t  v_i,
  input  sep_sched_t  w_i,
  input  logic [63:0] k_i,
  output sep_state_t  v_o,
  output logic [63:0] w_new_o
);

  logic [63:0] s1, ch, t1, s0, maj, t2, ls0, ls1;

  always_comb begin
    s1  = rotr(v_i[4], 14) ^ rotr(v_i[4], 18) ^ rotr(v_i[4], 41);
    ch  = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    t1  = v_i[7] + s1 + ch + k_i + w_i[0];
    s0  = rotr(v_i[0], 28) ^ rotr(v_i[0], 34) ^ rotr(v_i[0], 39);
    maj = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t2  = s0 + maj;
    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;
    // schedule word sixteen ahead of the current one
    ls0 = rotr(w_i[1], 1) ^ rotr(w_i[1], 8) ^ (w_i[1] >> 7);
    ls1 = rotr(w_i[14], 19) ^ rotr(w_i[14], 61) ^ (w_i[14] >> 6);
    w_new_o = w_i[0] + ls0 + w_i[9] + ls1;
  end

endmodule

FILE: src/sha512_entropy_pool.sv
// sha-512 entropy pool: absorb, credit and generate sequencer around one round unit
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+---------------------------------------------
//  in      | in  | in_valid_i / in_stall_o | func, data_word, data_bytes, last_word,
//          |     |                         | credit_bits, request_bytes
//  out     | out | out_valid_o/out_stall_i | out_word, out_bytes, out_last, credit_level,
//          |     |                         | byte_total
//
// one word at a time; in_stall_o is high from acceptance until the word is finished
// absorb word: each byte is written into the block in turn; a full 128-byte block is compressed
// (80 rounds on the single round unit, one chain add; the load rides on the byte write)
// closing word: pads one byte per cycle up to byte 112, held while a full block compresses,
// then one check, length, 80 rounds, chain add, pool update and status
// generate: per 64-byte block hash pool and counter, emit up to eight words; then the reseed
// reset clears control, pool, counter and totals; the hash working store needs no reset
// results wait in one output register; the sequencer holds while it is full and stalled
module sha512_entropy_pool
  import sep_pkg::*;
#(
  parameter int unsigned MAX_REQUEST_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  data_bytes_i,
  input  logic        last_word_i,
  input  logic [15:0] credit_bits_i,
  input  logic [9:0]  request_bytes_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_word_o,
  output logic [3:0]  out_bytes_o,
  output logic        out_last_o,
  output logic [9:0]  credit_level_o,
  output logic [63:0] byte_total_o
);

  localparam logic [9:0] MaxReq = 10'(MAX_REQUEST_BYTES);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BYTE = 4'd1;  // feed source bytes
  localparam logic [3:0] S_PAD  = 4'd2;  // 0x80 then zeros up to byte 112
  localparam logic [3:0] S_LEN  = 4'd3;  // length words
  localparam logic [3:0] S_RND  = 4'd4;  // 80 rounds
  localparam logic [3:0] S_ADD  = 4'd5;  // chain update
  localparam logic [3:0] S_FIN  = 4'd6;  // digest ready
  localparam logic [3:0] S_EMIT = 4'd7;  // random words out
  localparam logic [3:0] S_STAT = 4'd8;  // status word out

  logic [3:0]  state_q, state_d, ret_q, ret_d;
  logic [1:0]  op_q, op_d;
  logic        cr_q, cr_d, last_q, last_d, pad1_q, pad1_d, zreq_q, zreq_d;
  logic [15:0] credit_q, credit_d;
  logic [63:0] data_q, data_d;
  logic [3:0]  n_q, n_d, idx_q, idx_d;
  logic [9:0]  left_q, left_d;
  logic [2:0]  wsel_q, wsel_d;
  logic [6:0]  rnd_q, rnd_d, fill_q, fill_d;
  logic [63:0] len_q, len_d, ctr_q, ctr_d, abs_q, abs_d;
  logic [9:0]  cred_q, cred_d;
  sep_state_t  pool_q, pool_d;

  // hash working store
  sep_state_t  chain_q, v_q, v_rnd;
  sep_sched_t  msg_q;
  logic [63:0] w_new;

  // datapath controls
  logic        do_begin, wr_en, len_wr, rnd_step, v_load, chain_add;
  logic [7:0]  wr_b, src_b;

  // output register
  logic        ovalid_q, olast_q;
  logic [63:0] oword_q, ototal_q;
  logic [3:0]  obytes_q;
  logic [9:0]  ocred_q;
  logic        out_free, emit_go, emit_last;
  logic [63:0] emit_word, bsw;
  logic [3:0]  emit_n;
  logic [16:0] cred_sum;
  logic [3:0]  nb_sat;

  sep_round u_round (
    .v_i    (v_q),
    .w_i    (msg_q),
    .k_i    (SHA_K[rnd_q]),
    .v_o    (v_rnd),
    .w_new_o(w_new)
  );

  assign out_free = !ovalid_q || !out_stall_i;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      bsw[8*j +: 8] = chain_q[wsel_q][8*(7-j) +: 8];
    end
  end

  always_comb begin
    case (op_q)
      OP_ABS:  src_b = data_q[{idx_q[2:0], 3'b000} +: 8];
      OP_GEN:  src_b = ctr_q[{idx_q[2:0], 3'b000} +: 8];
      default: src_b = tag_byte(idx_q[2:0]);
    endcase
  end

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    op_d     = op_q;
    cr_d     = cr_q;
    last_d   = last_q;
    pad1_d   = pad1_q;
    zreq_d   = zreq_q;
    credit_d = credit_q;
    data_d   = data_q;
    n_d      = n_q;
    idx_d    = idx_q;
    left_d   = left_q;
    wsel_d   = wsel_q;
    rnd_d    = rnd_q;
    fill_d   = fill_q;
    len_d    = len_q;
    ctr_d    = ctr_q;
    abs_d    = abs_q;
    cred_d   = cred_q;
    pool_d   = pool_q;
    do_begin  = 1'b0;
    wr_en     = 1'b0;
    wr_b      = 8'h00;
    len_wr    = 1'b0;
    rnd_step  = 1'b0;
    v_load    = 1'b0;
    chain_add = 1'b0;
    emit_go   = 1'b0;
    emit_word = 64'h0;
    emit_n    = 4'd0;
    emit_last = 1'b1;
    nb_sat    = (data_bytes_i > 4'd8) ? 4'd8 : data_bytes_i;
    cred_sum  = 17'(cred_q) + 17'(credit_q);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d = 4'd0;
          if (func_i inside {FUNC_CREDIT, FUNC_SEED}) begin
            op_d     = OP_ABS;
            cr_d     = (func_i == FUNC_CREDIT);
            last_d   = last_word_i;
            credit_d = credit_bits_i;
            data_d   = data_word_i;
            n_d      = nb_sat;
            // a new absorb starts from the pool
            if (len_q == 64'd0) do_begin = 1'b1;
            state_d  = S_BYTE;
          end else if (func_i == FUNC_GEN) begin
            left_d   = (request_bytes_i > MaxReq) ? MaxReq : request_bytes_i;
            zreq_d   = (request_bytes_i == 10'd0);
            op_d     = (request_bytes_i == 10'd0) ? OP_RSD : OP_GEN;
            n_d      = (request_bytes_i == 10'd0) ? 4'd7 : 4'd8;
            do_begin = 1'b1;
            state_d  = S_BYTE;
          end else begin
            // unused code: status only, pending absorb kept
            state_d = S_STAT;
          end
        end
      end
      S_BYTE: begin
        if (idx_q == n_q) begin
          if (op_q == OP_ABS) begin
            if (last_q) begin
              if (len_q != 64'd64) begin
                pad1_d  = 1'b1;
                state_d = S_PAD;
              end else begin
                // empty absorb leaves the pool alone
                len_d   = 64'd0;
                fill_d  = 7'd0;
                state_d = S_STAT;
              end
            end else begin
              state_d = S_STAT;
            end
          end else begin
            pad1_d  = 1'b1;
            state_d = S_PAD;
          end
        end else begin
          wr_en  = 1'b1;
          wr_b   = src_b;
          fill_d = fill_q + 7'd1;
          len_d  = len_q + 64'd1;
          idx_d  = idx_q + 4'd1;
          if (fill_q == 7'd127) begin
            v_load  = 1'b1;
            rnd_d   = 7'd0;
            ret_d   = S_BYTE;
            state_d = S_RND;
          end
        end
      end
      S_PAD: begin
        if (pad1_q || fill_q != 7'd112) begin
          wr_en  = 1'b1;
          wr_b   = pad1_q ? 8'h80 : 8'h00;
          pad1_d = 1'b0;
          fill_d = fill_q + 7'd1;
          if (fill_q == 7'd127) begin
            v_load  = 1'b1;
            rnd_d   = 7'd0;
            ret_d   = S_PAD;
            state_d = S_RND;
          end
        end else begin
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        len_wr  = 1'b1;
        fill_d  = 7'd0;
        v_load  = 1'b1;
        rnd_d   = 7'd0;
        ret_d   = S_FIN;
        state_d = S_RND;
      end
      S_RND: begin
        rnd_step = 1'b1;
        rnd_d    = rnd_q + 7'd1;
        if (rnd_q == 7'd79) state_d = S_ADD;
      end
      S_ADD: begin
        chain_add = 1'b1;
        state_d   = ret_q;
      end
      S_FIN: begin
        len_d  = 64'd0;
        fill_d = 7'd0;
        case (op_q)
          OP_ABS: begin
            pool_d = chain_q;
            if (cr_q) begin
              abs_d  = abs_q + (len_q - 64'd64);
              cred_d = (cred_sum > 17'(ENTROPY_CAP)) ? ENTROPY_CAP : cred_sum[9:0];
            end
            state_d = S_STAT;
          end
          OP_GEN: begin
            ctr_d   = ctr_q + 64'd1;
            wsel_d  = 3'd0;
            state_d = S_EMIT;
          end
          default: begin
            pool_d  = chain_q;
            state_d = zreq_q ? S_STAT : S_IDLE;
          end
        endcase
      end
      S_EMIT: begin
        if (out_free) begin
          emit_go   = 1'b1;
          emit_n    = (left_q >= 10'd8) ? 4'd8 : left_q[3:0];
          emit_last = (left_q == 10'(emit_n));
          for (int j = 0; j < 8; j++) begin
            emit_word[8*j +: 8] = (4'(j) < emit_n) ? bsw[8*j +: 8] : 8'h00;
          end
          left_d = left_q - 10'(emit_n);
          idx_d  = 4'd0;
          if (emit_last) begin
            op_d     = OP_RSD;
            n_d      = 4'd7;
            do_begin = 1'b1;
            state_d  = S_BYTE;
          end else if (wsel_q == 3'd7) begin
            op_d     = OP_GEN;
            n_d      = 4'd8;
            do_begin = 1'b1;
            state_d  = S_BYTE;
          end else begin
            wsel_d = wsel_q + 3'd1;
          end
        end
      end
      S_STAT: begin
        if (out_free) begin
          emit_go = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (do_begin) begin
      fill_d = 7'd64;
      len_d  = 64'd64;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      op_q     <= OP_ABS;
      cr_q     <= 1'b0;
      last_q   <= 1'b0;
      pad1_q   <= 1'b0;
      zreq_q   <= 1'b0;
      n_q      <= 4'd0;
      idx_q    <= 4'd0;
      left_q   <= 10'd0;
      wsel_q   <= 3'd0;
      rnd_q    <= 7'd0;
      fill_q   <= 7'd0;
      len_q    <= 64'd0;
      ctr_q    <= 64'd0;
      abs_q    <= 64'd0;
      cred_q   <= 10'd0;
      pool_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      op_q    <= op_d;
      cr_q    <= cr_d;
      last_q  <= last_d;
      pad1_q  <= pad1_d;
      zreq_q  <= zreq_d;
      n_q     <= n_d;
      idx_q   <= idx_d;
      left_q  <= left_d;
      wsel_q  <= wsel_d;
      rnd_q   <= rnd_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      ctr_q   <= ctr_d;
      abs_q   <= abs_d;
      cred_q  <= cred_d;
      pool_q  <= pool_d;
      if (emit_go) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // payload, output and hash working store registers
  always_ff @(posedge clk_i) begin
    credit_q <= credit_d;
    data_q   <= data_d;
    if (emit_go) begin
      oword_q  <= emit_word;
      obytes_q <= emit_n;
      olast_q  <= emit_last;
      ocred_q  <= cred_q;
      ototal_q <= abs_q;
    end
    if (do_begin) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= SHA_IV[i];
        msg_q[i]   <= pool_q[i];
      end
    end else if (chain_add) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= chain_q[i] + v_q[i];
      end
    end
    if (v_load) begin
      v_q <= chain_q;
    end else if (rnd_step) begin
      v_q <= v_rnd;
    end
    if (wr_en) begin
      msg_q[fill_q[6:3]][{~fill_q[2:0], 3'b000} +: 8] <= wr_b;
    end else if (len_wr) begin
      msg_q[14] <= {61'd0, len_q[63:61]};
      msg_q[15] <= {len_q[60:0], 3'b000};
    end else if (rnd_step) begin
      for (int i = 0; i < 15; i++) begin
        msg_q[i] <= msg_q[i+1];
      end
      msg_q[15] <= w_new;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = ovalid_q;
  assign out_word_o     = oword_q;
  assign out_bytes_o    = obytes_q;
  assign out_last_o     = olast_q;
  assign credit_level_o = ocred_q;
  assign byte_total_o   = ototal_q;

  // status words always close their item
  a_status_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_bytes_o == 4'd0 |-> out_last_o)
    else $error("status word without last flag");

  // entropy credit never passes the cap
  a_cred_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cred_q <= ENTROPY_CAP)
    else $error("credited entropy above cap");

  // a finished generate block goes straight to emitting
  a_gen_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && op_q == OP_GEN |=> state_q == S_EMIT)
    else $error("generate block not emitted");

  // round counter stays in range while compressing
  a_rnd_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RND |-> rnd_q <= 7'd79)
    else $error("round counter out of range");

endmodule
